// ----- rtl/sdss_pkg.sv -----
// Shared types, constants and the segment table for the signed decimal
// seven-segment decoder. No dependencies.
`default_nettype none

package sdss_pkg;

  localparam int VAL_W   = 21;  // input word width, two's complement
  localparam int MAG_W   = 20;  // magnitude width, holds up to 999999
  localparam int DIGIT_W = 4;
  localparam int SEG_W   = 7;
  localparam int PLACES  = 6;
  localparam int PROD_W  = 2 * MAG_W;

  localparam logic signed [VAL_W-1:0] MAX_SHOWN = 21'sd999999;
  localparam logic signed [VAL_W-1:0] MIN_SHOWN = -21'sd99999;

  // x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT, exact for x below about 4.1M
  localparam logic [MAG_W-1:0] DIV10_MUL   = 20'd838861;
  localparam int               DIV10_SHIFT = 23;

  localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;
  localparam logic [SEG_W-1:0] SEG_MINUS = 7'h40;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [SEG_W-1:0]   seg_t;

  // Payload that travels down the digit pipeline
  typedef struct packed {
    logic [MAG_W-1:0]         mag;     // part of the magnitude not yet split
    digit_t [PLACES-1:0]      digits;  // shifted in from the top
    logic   [PLACES-1:0]      live;    // digit is significant
    logic                     neg;
    logic                     oor;
  } work_t;

  typedef struct packed {
    seg_t [PLACES-1:0] seg;
    logic              oor;
  } result_t;

  function automatic seg_t digit_seg(input digit_t d);
    seg_t s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sdss_if.sv -----
// Valid/ready channel interfaces for the input word and the result word.
// Depends on sdss_pkg.
`default_nettype none

interface sdss_in_if
  import sdss_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] signed_value;

  modport source (output valid, output signed_value, input ready);
  modport sink   (input valid, input signed_value, output ready);
endinterface

interface sdss_out_if
  import sdss_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [SEG_W-1:0] seg_place0;
  logic [SEG_W-1:0] seg_place1;
  logic [SEG_W-1:0] seg_place2;
  logic [SEG_W-1:0] seg_place3;
  logic [SEG_W-1:0] seg_place4;
  logic [SEG_W-1:0] seg_place5;
  logic             out_of_range;

  modport source (output valid, output seg_place0, output seg_place1, output seg_place2,
                  output seg_place3, output seg_place4, output seg_place5,
                  output out_of_range, input ready);
  modport sink   (input valid, input seg_place0, input seg_place1, input seg_place2,
                  input seg_place3, input seg_place4, input seg_place5,
                  input out_of_range, output ready);
endinterface

`default_nettype wire

// ----- rtl/sdss_front.sv -----
// Front stage: range check and magnitude of the input word.
// Depends on sdss_pkg.
`default_nettype none

module sdss_front
  import sdss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             valid_i,
  output      logic             ready_o,
  input  wire logic [VAL_W-1:0] value_i,
  output      logic             valid_o,
  input  wire logic             ready_i,
  output      work_t            data_o
);

  logic  vld_r;
  work_t data_r, data_nxt;
  logic signed [VAL_W-1:0] v;
  logic [VAL_W-1:0] neg_v;

  assign v       = $signed(value_i);
  assign neg_v   = VAL_W'(-v);
  assign ready_o = !vld_r || ready_i;

  always_comb begin
    data_nxt        = '0;
    data_nxt.neg    = v[VAL_W-1];
    data_nxt.oor    = (v > MAX_SHOWN) || (v < MIN_SHOWN);
    if (!data_nxt.oor) begin
      data_nxt.mag = data_nxt.neg ? neg_v[MAG_W-1:0] : value_i[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_o) begin
      vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = vld_r;
  assign data_o  = data_r;

endmodule

`default_nettype wire

// ----- rtl/sdss_digit_stage.sv -----
// One decimal digit per stage: divides the magnitude by ten with a
// reciprocal multiply and shifts the remainder into the digit list. Uses sdss_pkg.
`default_nettype none

module sdss_digit_stage
  import sdss_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  valid_i,
  output      logic  ready_o,
  input  wire work_t data_i,
  output      logic  valid_o,
  input  wire logic  ready_i,
  output      work_t data_o
);

  logic  vld_r;
  work_t data_r, data_nxt;
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  quot;
  logic [MAG_W-1:0]  times10;
  logic [MAG_W-1:0]  rem;

  assign ready_o = !vld_r || ready_i;
  assign prod    = PROD_W'(data_i.mag) * PROD_W'(DIV10_MUL);
  assign quot    = MAG_W'(prod >> DIV10_SHIFT);
  assign times10 = (quot << 3) + (quot << 1);
  assign rem     = data_i.mag - times10;

  always_comb begin
    data_nxt        = data_i;
    data_nxt.mag    = quot;
    data_nxt.digits = {rem[DIGIT_W-1:0], data_i.digits[PLACES-1:1]};
    data_nxt.live   = {(data_i.mag != '0), data_i.live[PLACES-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_o) begin
      vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = vld_r;
  assign data_o  = data_r;

endmodule

`default_nettype wire

// ----- rtl/sdss_encode.sv -----
// Final stage: digits to segment patterns, leading blanks and the minus
// sign; registered result word. Depends on sdss_pkg.
`default_nettype none

module sdss_encode
  import sdss_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    valid_i,
  output      logic    ready_o,
  input  wire work_t   data_i,
  output      logic    valid_o,
  input  wire logic    ready_i,
  output      result_t res_o
);

  logic    vld_r;
  result_t res_r, res_nxt;
  logic [PLACES-1:0] show;

  assign ready_o = !vld_r || ready_i;
  // ones place always shows a digit, so zero reads "0"
  assign show    = data_i.live | PLACES'(1);

  always_comb begin
    res_nxt     = '0;
    res_nxt.oor = data_i.oor;
    for (int i = 0; i < PLACES; i++) begin
      if (data_i.oor) begin
        res_nxt.seg[i] = SEG_BLANK;
      end else if (show[i]) begin
        res_nxt.seg[i] = digit_seg(data_i.digits[i]);
      end else if (data_i.neg && (i > 0) && show[(i > 0) ? i - 1 : 0]) begin
        res_nxt.seg[i] = SEG_MINUS;
      end else begin
        res_nxt.seg[i] = SEG_BLANK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_o) begin
      vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      res_r <= res_nxt;
    end
  end

  assign valid_o = vld_r;
  assign res_o   = res_r;

endmodule

`default_nettype wire

// ----- rtl/signed_decimal_seven_segment_top.sv -----
// Signed decimal seven-segment decoder. A 21-bit two's complement word
// becomes six segment patterns (bit 0 = a .. bit 6 = g), ones place first,
// with leading blanks, a minus sign just above the top digit of a negative
// value, and an out-of-range flag (all patterns 0) above 999999 or below
// -99999. One word is taken every cycle unless out_ch stalls. The pipeline
// is a range and magnitude stage, six divide-by-ten stages (one reciprocal
// multiply each) and a segment encode stage. Ready is combinational from
// out_ch back through the stages; a stalled word is held, never dropped.
// Depends on sdss_pkg, sdss_if, sdss_front, sdss_digit_stage, sdss_encode.
`default_nettype none

module signed_decimal_seven_segment_top
  import sdss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  sdss_in_if.sink   in_ch,
  sdss_out_if.source out_ch
);

  logic  [PLACES:0] vld;
  logic  [PLACES:0] rdy;
  work_t            work [PLACES+1];
  logic             enc_ready;
  result_t          res;

  sdss_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_ch.valid),
    .ready_o (in_ch.ready),
    .value_i (in_ch.signed_value),
    .valid_o (vld[0]),
    .ready_i (rdy[0]),
    .data_o  (work[0])
  );

  for (genvar g = 0; g < PLACES; g++) begin : g_digit
    sdss_digit_stage u_digit (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (vld[g]),
      .ready_o (rdy[g]),
      .data_i  (work[g]),
      .valid_o (vld[g+1]),
      .ready_i (rdy[g+1]),
      .data_o  (work[g+1])
    );
  end

  assign rdy[PLACES] = enc_ready;

  sdss_encode u_encode (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (vld[PLACES]),
    .ready_o (enc_ready),
    .data_i  (work[PLACES]),
    .valid_o (out_ch.valid),
    .ready_i (out_ch.ready),
    .res_o   (res)
  );

  assign out_ch.seg_place0   = res.seg[0];
  assign out_ch.seg_place1   = res.seg[1];
  assign out_ch.seg_place2   = res.seg[2];
  assign out_ch.seg_place3   = res.seg[3];
  assign out_ch.seg_place4   = res.seg[4];
  assign out_ch.seg_place5   = res.seg[5];
  assign out_ch.out_of_range = res.oor;

`ifndef SYNTHESIS
  // out of range words carry no pattern at all
  a_oor_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && res.oor) |-> (res.seg == '0))
    else $error("out-of-range word carries segment bits");

  // a shown value always has a digit in the ones place
  a_ones_lit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !res.oor) |-> (res.seg[0] != SEG_BLANK) && (res.seg[0] != SEG_MINUS))
    else $error("ones place blank or minus");

  // at most one minus sign in a word
  a_one_minus: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ($countones({res.seg[5] == SEG_MINUS, res.seg[4] == SEG_MINUS,
                                  res.seg[3] == SEG_MINUS, res.seg[2] == SEG_MINUS,
                                  res.seg[1] == SEG_MINUS}) <= 1))
    else $error("more than one minus sign");
`endif

endmodule

`default_nettype wire
